[rtl/hil_pkg.sv]
// Shared constants and coefficient helpers for the Hilbert I/Q generator.
package hil_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int TAPS_DEF      = 51;
    localparam int COEF_BITS_DEF = 16;
    localparam int HALF_LEN      = 13;
    localparam int GROUP_SIZE    = 4;
    localparam int NUM_GROUPS    = (HALF_LEN + GROUP_SIZE - 1) / GROUP_SIZE;

    // Q1.15 magnitudes for tap offsets 1, 3, 5, ... 25 from the centre.
    localparam int MAG_Q15 [HALF_LEN] = '{
        20810, 6804, 3926, 2643, 1897, 1401, 1045, 778, 572, 413, 289, 194, 193
    };

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [DIFF_BITS-1:0]   diff_t;

    // Magnitude of coefficient pair j rescaled to Q1.(cbits-1), rounded when narrowed.
    function automatic int coef_mag(input int j, input int cbits);
        int m;
        m = MAG_Q15[j];
        if (cbits > 16) begin
            m = m <<< (cbits - 16);
        end
        else if (cbits < 16) begin
            m = (m + (1 <<< (15 - cbits))) >>> (16 - cbits);
        end
        return m;
    endfunction

endpackage

[rtl/hil_delay_line.sv]
// Sample history shift line and antisymmetric pair pre-subtraction.
module hil_delay_line import hil_pkg::*; #(
    parameter int TAPS = TAPS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift_en,
    input  sample_t sample,
    output diff_t   diff [HALF_LEN],
    output sample_t centre
);

    localparam int DEPTH = TAPS - 1;
    localparam int DELAY = (TAPS - 1) / 2;

    sample_t hist_reg  [DEPTH];
    sample_t hist_next [DEPTH];
    sample_t win       [TAPS];

    assign win[0] = sample;

    for (genvar k = 1; k < TAPS; k++) begin : g_win
        assign win[k] = hist_reg[k-1];
    end

    always_comb
    begin
        hist_next[0] = sample;
        for (int i = 1; i < DEPTH; i++) begin
            hist_next[i] = hist_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
        end
        else if (shift_en) begin
            hist_reg <= hist_next;
        end
    end

    assign centre = hist_reg[DELAY-1];

    for (genvar j = 0; j < HALF_LEN; j++) begin : g_pair
        localparam int OFS = 2 * j + 1;
        localparam int KP  = DELAY + OFS;
        localparam int KN  = DELAY - OFS;
        diff_t pos_ext;
        diff_t neg_ext;
        if (KP <= TAPS - 1) begin : g_pos
            assign pos_ext = DIFF_BITS'(win[KP]);
        end
        else begin : g_pos_none
            assign pos_ext = '0;
        end
        if (KN >= 0) begin : g_neg
            assign neg_ext = DIFF_BITS'(win[KN]);
        end
        else begin : g_neg_none
            assign neg_ext = '0;
        end
        assign diff[j] = pos_ext - neg_ext;
    end

endmodule

[rtl/hil_mac_pipe.sv]
// Multiply, adder tree, rounding and saturation pipeline with elastic stages.
module hil_mac_pipe import hil_pkg::*; #(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  diff_t   diff [HALF_LEN],
    input  sample_t centre,
    output logic    out_valid,
    input  logic    out_ready,
    output sample_t in_phase,
    output sample_t quadrature
);

    localparam int PROD_W = DIFF_BITS + COEF_BITS;
    localparam int GRP_W  = PROD_W + 2;
    localparam int ACC_W  = PROD_W + 5;
    localparam int FRAC   = COEF_BITS - 1;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (FRAC - 1);
    localparam logic signed [ACC_W-1:0] QHI = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] QLO = ~QHI;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    diff_t                     diff_reg [HALF_LEN];
    logic signed [PROD_W-1:0]  prod_next [HALF_LEN];
    logic signed [PROD_W-1:0]  prod_reg  [HALF_LEN];
    logic signed [GRP_W-1:0]   grp_next  [NUM_GROUPS];
    logic signed [GRP_W-1:0]   grp_reg   [NUM_GROUPS];
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   q_full;
    sample_t                   quad_next;
    sample_t                   quad_reg;
    sample_t                   ip1_reg, ip2_reg, ip3_reg, ip4_reg, ip5_reg;

    assign rdy5 = !v5_reg || out_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    for (genvar j = 0; j < HALF_LEN; j++) begin : g_mul
        localparam int MAGV = coef_mag(j, COEF_BITS);
        localparam logic signed [COEF_BITS-1:0] CJ = COEF_BITS'(MAGV);
        assign prod_next[j] = PROD_W'(diff_reg[j]) * PROD_W'(CJ);
    end

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_next[g] = '0;
            for (int i = 0; i < GROUP_SIZE; i++) begin
                if (g * GROUP_SIZE + i < HALF_LEN) begin
                    grp_next[g] = grp_next[g] + GRP_W'(prod_reg[g * GROUP_SIZE + i]);
                end
            end
        end
    end

    always_comb
    begin
        acc_next = RND;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            acc_next = acc_next + ACC_W'(grp_reg[g]);
        end
    end

    always_comb
    begin
        q_full = acc_reg >>> FRAC;
        if (q_full > QHI) begin
            quad_next = QHI[SAMPLE_BITS-1:0];
        end
        else if (q_full < QLO) begin
            quad_next = QLO[SAMPLE_BITS-1:0];
        end
        else begin
            quad_next = q_full[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1) begin
            diff_reg <= diff;
            ip1_reg  <= centre;
        end
        if (rdy2) begin
            prod_reg <= prod_next;
            ip2_reg  <= ip1_reg;
        end
        if (rdy3) begin
            grp_reg <= grp_next;
            ip3_reg <= ip2_reg;
        end
        if (rdy4) begin
            acc_reg <= acc_next;
            ip4_reg <= ip3_reg;
        end
        if (rdy5) begin
            quad_reg <= quad_next;
            ip5_reg  <= ip4_reg;
        end
    end

    assign out_valid  = v5_reg;
    assign in_phase   = ip5_reg;
    assign quadrature = quad_reg;

    a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !v5_reg |-> in_ready)
        else $error("pipeline refuses a beat while the output stage is empty");

    a_stage4_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && rdy5) |=> v5_reg)
        else $error("sum stage beat lost on its way to the output stage");

    a_acc_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !rdy5) |=> (v4_reg && $stable(acc_reg)))
        else $error("stalled accumulator changed");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg))
        else $error("input stalled with a bubble in the pipeline");

endmodule

[rtl/fir_hilbert_iq_generator.sv]
// Top level of the Hilbert-transform I/Q generator.
//
//  Channel   Signals                                       Direction
//  sample    sample_valid, sample_ready, sample            in
//  result    result_valid, result_ready, in_phase,         out
//            quadrature
//
// One beat per clock is accepted while the result side does not stall. A result passes
// through the input, product, group-sum, accumulator and output registers in that order.
// The rate is set by the five-stage multiply and adder-tree pipeline, one beat per stage.
// Reset clears the sample history to zero and empties the pipeline.
// A stall on the result side fills bubbles first, then holds the input side.
module fir_hilbert_iq_generator import hil_pkg::*; #(
    parameter int TAPS      = TAPS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_ready,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_ready,
    output sample_t in_phase,
    output sample_t quadrature
);

    diff_t   diff [HALF_LEN];
    sample_t centre;
    logic    accept;

    assign accept = sample_valid && sample_ready;

    hil_delay_line #(
        .TAPS (TAPS)
    ) u_delay (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (accept),
        .sample   (sample),
        .diff     (diff),
        .centre   (centre)
    );

    hil_mac_pipe #(
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample_valid),
        .in_ready   (sample_ready),
        .diff       (diff),
        .centre     (centre),
        .out_valid  (result_valid),
        .out_ready  (result_ready),
        .in_phase   (in_phase),
        .quadrature (quadrature)
    );

endmodule
